FILE: hw/rtl/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg: shared types and constants of the huffman stream decoder
// Item types of both channels, table sizes and state encodings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsd_pkg;

	// table sizes
	localparam int unsigned MAX_NODES   = 512;
	localparam int unsigned STACK_DEPTH = 256;

	localparam int unsigned SYM_W   = 8;
	localparam int unsigned NODE_AW = $clog2(MAX_NODES);
	localparam int unsigned NODE_CW = $clog2(MAX_NODES + 1);
	localparam int unsigned STK_AW  = $clog2(STACK_DEPTH);
	localparam int unsigned STK_CW  = $clog2(STACK_DEPTH + 1);
	// left word holds a child index or a symbol, plus the leaf flag on top
	localparam int unsigned LVAL_W  = (NODE_AW > SYM_W) ? NODE_AW : SYM_W;
	localparam int unsigned LEFT_W  = LVAL_W + 1;
	// pending slot: node index and side
	localparam int unsigned SLOT_W  = NODE_AW + 1;

	localparam logic [3:0] LEAF_BITS = 4'd8;

	// input item
	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_trailer;
	} comp_t;

	// result item
	typedef struct packed {
		logic [7:0] out_symbol;
		logic       symbol_valid;
		logic       last_of_run;
		logic       end_of_stream;
		logic       malformed;
	} dec_t;

	// stream phase
	typedef enum logic [1:0] {
		PH_TREE = 2'd0,
		PH_DATA = 2'd1,
		PH_END  = 2'd2,
		PH_BAD  = 2'd3
	} phase_t;

	// item sequencer
	typedef enum logic [1:0] {
		CT_IDLE,
		CT_RUN,
		CT_DONE
	} ctl_t;

endpackage

FILE: hw/rtl/hsd_ram.sv
// ----------------------------------------------------------------------------
// hsd_ram: simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/huffman_stream_decoder.sv
// ----------------------------------------------------------------------------
// huffman_stream_decoder: preorder-tree huffman byte stream decoder
// Operation: a full byte is accepted, shifted one bit per cycle while the output
//   does not stall, and closed; in the data phase one more step drains the last
//   node table read before the item closes.
// Items: the next byte is taken only once the current item has closed, and
//   output stalls hold the item; a trimmed trailer byte shifts fewer bits.
// Reset: control state clears at once; node table and slot stack are not
//   cleared, each entry in use is written while the header is parsed before use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_stream_decoder import hsd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  comp_valid,
	output logic  comp_stall,
	input  comp_t comp,
	output logic  dec_valid,
	input  logic  dec_stall,
	output dec_t  dec
);

	// control registers
	ctl_t               state_q, state_n;
	phase_t             phase_q, phase_n;
	logic [NODE_CW-1:0] node_cnt_q, node_cnt_n;
	logic [STK_CW-1:0]  stk_top_q, stk_top_n;
	logic               tos_ld_q, tos_ld_n;
	logic [3:0]         leaf_left_q, leaf_left_n;
	logic               held_ok_q, held_ok_n;
	logic [3:0]         bits_q, bits_n;
	logic               wp_q, wp_n;
	logic               trl_q, trl_n;
	logic               eos_q, eos_n;
	logic               hs_valid_q, hs_valid_n;
	logic               dec_valid_q, dec_valid_n;

	// payload registers
	logic [SLOT_W-1:0]  tos_q, tos_n;
	logic [NODE_AW-1:0] cur_idx_q, cur_idx_n;
	logic [7:0]         leaf_sh_q, leaf_sh_n;
	logic [NODE_AW-1:0] cur_l_q, cur_l_n;
	logic [NODE_AW-1:0] cur_r_q, cur_r_n;
	logic [LEFT_W-1:0]  root_l_q, root_l_n;
	logic [NODE_AW-1:0] root_r_q, root_r_n;
	logic [7:0]         held_q, held_n;
	logic [7:0]         sh_q, sh_n;
	logic [7:0]         hs_sym_q, hs_sym_n;
	dec_t               dec_q, dec_n;

	// memory ports
	logic               l_we, r_we, n_re, s_we, s_re;
	logic [NODE_AW-1:0] l_wa, r_wa, n_ra;
	logic [LEFT_W-1:0]  l_wd, l_rd;
	logic [NODE_AW-1:0] r_wd, r_rd;
	logic [STK_AW-1:0]  s_wa, s_ra;
	logic [SLOT_W-1:0]  s_wd, s_rd;

	logic out_free;
	logic go;

	// node table: left word (leaf flag, left child or symbol) and right child
	hsd_ram #(.WIDTH(LEFT_W), .DEPTH(MAX_NODES)) u_left_ram (
		.clk     (clk),
		.wr_en   (l_we),
		.wr_addr (l_wa),
		.wr_data (l_wd),
		.rd_en   (n_re),
		.rd_addr (n_ra),
		.rd_data (l_rd)
	);

	hsd_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_NODES)) u_right_ram (
		.clk     (clk),
		.wr_en   (r_we),
		.wr_addr (r_wa),
		.wr_data (r_wd),
		.rd_en   (n_re),
		.rd_addr (n_ra),
		.rd_data (r_rd)
	);

	// pending child slots below the top, the top lives in tos_q
	hsd_ram #(.WIDTH(SLOT_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk     (clk),
		.wr_en   (s_we),
		.wr_addr (s_wa),
		.wr_data (s_wd),
		.rd_en   (s_re),
		.rd_addr (s_ra),
		.rd_data (s_rd)
	);

	// output register handshake
	assign out_free   = !dec_valid_q || !dec_stall;
	assign go         = out_free || !hs_valid_q;
	assign comp_stall = (state_q != CT_IDLE);
	assign dec_valid  = dec_valid_q;
	assign dec        = dec_q;

	// next state and datapath
	always_comb begin
		logic               b;
		logic               active;
		logic               bit_act;
		logic               emit_v;
		logic [7:0]         emit_sym;
		logic [7:0]         leaf_nx;
		logic [NODE_AW-1:0] cur_l_e;
		logic [NODE_AW-1:0] cur_r_e;
		logic [NODE_AW-1:0] idx;
		logic [NODE_AW-1:0] par;
		logic [STK_CW-1:0]  top_pop;
		logic [STK_CW-1:0]  top_dec;
		logic               alloc_ok;

		state_n     = state_q;
		phase_n     = phase_q;
		node_cnt_n  = node_cnt_q;
		stk_top_n   = stk_top_q;
		tos_ld_n    = 1'b0;
		leaf_left_n = leaf_left_q;
		held_ok_n   = held_ok_q;
		bits_n      = bits_q;
		wp_n        = wp_q;
		trl_n       = trl_q;
		eos_n       = eos_q;
		hs_valid_n  = hs_valid_q;
		tos_n       = tos_q;
		cur_idx_n   = cur_idx_q;
		leaf_sh_n   = leaf_sh_q;
		cur_l_n     = cur_l_q;
		cur_r_n     = cur_r_q;
		root_l_n    = root_l_q;
		root_r_n    = root_r_q;
		held_n      = held_q;
		sh_n        = sh_q;
		hs_sym_n    = hs_sym_q;
		dec_valid_n = dec_valid_q && dec_stall;
		dec_n       = dec_q;

		l_we = 1'b0;
		l_wa = cur_idx_q;
		l_wd = root_l_q;
		r_we = 1'b0;
		r_wa = cur_idx_q;
		r_wd = cur_r_q;
		n_re = 1'b0;
		n_ra = cur_l_q;
		s_we = 1'b0;
		s_wa = stk_top_q[STK_AW-1:0];
		s_wd = tos_q;
		s_re = 1'b0;
		s_ra = stk_top_q[STK_AW-1:0];

		b        = sh_q[7];
		active   = phase_q inside {PH_TREE, PH_DATA};
		bit_act  = (bits_q != 4'd0) && active;
		emit_v   = 1'b0;
		emit_sym = 8'd0;
		leaf_nx  = {leaf_sh_q[6:0], b};
		cur_l_e  = cur_l_q;
		cur_r_e  = cur_r_q;
		idx      = node_cnt_q[NODE_AW-1:0];
		par      = tos_q[SLOT_W-1:1];
		top_pop  = stk_top_q;
		top_dec  = stk_top_q;
		alloc_ok = 1'b1;

		// top of slot stack comes back from the stack RAM in the cycle after a leaf pops it
		if (tos_ld_q) begin
			tos_n = s_rd;
		end

		case (state_q)
			CT_IDLE: begin
				if (comp_valid) begin
					// the held byte is decoded now, trimmed if this is the trailer
					if (active && held_ok_q) begin
						bits_n = comp.is_trailer ?
							(LEAF_BITS - {1'b0, comp.in_byte[2:0]}) : LEAF_BITS;
					end else begin
						bits_n = 4'd0;
					end
					sh_n  = held_q;
					trl_n = comp.is_trailer && active;
					eos_n = comp.is_trailer || (phase_q == PH_END);
					if (active) begin
						if (comp.is_trailer) begin
							held_ok_n = 1'b0;
						end else begin
							held_n    = comp.in_byte;
							held_ok_n = 1'b1;
						end
					end
					state_n = CT_RUN;
				end
			end

			CT_RUN: begin
				if (go) begin
					// resolve the node read issued for the previous data bit
					if (wp_q) begin
						wp_n = 1'b0;
						if (l_rd[LVAL_W]) begin
							emit_v   = 1'b1;
							emit_sym = l_rd[SYM_W-1:0];
							cur_l_e  = root_l_q[NODE_AW-1:0];
							cur_r_e  = root_r_q;
						end else begin
							cur_l_e = l_rd[NODE_AW-1:0];
							cur_r_e = r_rd;
						end
						cur_l_n = cur_l_e;
						cur_r_n = cur_r_e;
					end

					if (bit_act) begin
						sh_n   = {sh_q[6:0], 1'b0};
						bits_n = bits_q - 4'd1;
						if (phase_q == PH_DATA) begin
							// walk one level, single-leaf tree emits on every bit
							if (root_l_q[LVAL_W]) begin
								emit_v   = 1'b1;
								emit_sym = root_l_q[SYM_W-1:0];
							end else begin
								n_re = 1'b1;
								n_ra = b ? cur_r_e : cur_l_e;
								wp_n = 1'b1;
							end
						end else if (leaf_left_q != 4'd0) begin
							// symbol bits of a leaf
							leaf_sh_n   = leaf_nx;
							leaf_left_n = leaf_left_q - 4'd1;
							if (leaf_left_q == 4'd1) begin
								l_we = 1'b1;
								l_wa = cur_idx_q;
								l_wd = {1'b1, LVAL_W'(leaf_nx)};
								if (cur_idx_q == '0) begin
									root_l_n = l_wd;
								end
								if (stk_top_q == '0) begin
									phase_n = PH_DATA;
									cur_l_n = root_l_q[NODE_AW-1:0];
									cur_r_n = root_r_q;
								end
							end
						end else if (node_cnt_q == NODE_CW'(MAX_NODES)) begin
							phase_n = PH_BAD;
						end else begin
							// new node: link it into the slot on top of the stack
							node_cnt_n = node_cnt_q + NODE_CW'(1);
							if (idx != '0) begin
								if (stk_top_q == '0) begin
									phase_n  = PH_BAD;
									alloc_ok = 1'b0;
								end else begin
									top_pop = stk_top_q - STK_CW'(1);
									if (tos_q[0]) begin
										r_we = 1'b1;
										r_wa = par;
										r_wd = idx;
										if (par == '0) begin
											root_r_n = idx;
										end
									end else begin
										l_we = 1'b1;
										l_wa = par;
										l_wd = {1'b0, LVAL_W'(idx)};
										if (par == '0) begin
											root_l_n = {1'b0, LVAL_W'(idx)};
										end
									end
								end
							end
							if (alloc_ok) begin
								if (!b) begin
									// internal node pushes right then left slot
									if (({1'b0, top_pop} + (STK_CW + 1)'(2)) >
										(STK_CW + 1)'(STACK_DEPTH)) begin
										phase_n = PH_BAD;
									end else begin
										s_we      = 1'b1;
										s_wa      = top_pop[STK_AW-1:0];
										s_wd      = {idx, 1'b1};
										tos_n     = {idx, 1'b0};
										stk_top_n = top_pop + STK_CW'(2);
									end
								end else begin
									// leaf: collect its symbol, refill the stack top
									cur_idx_n   = idx;
									leaf_left_n = LEAF_BITS;
									leaf_sh_n   = 8'd0;
									stk_top_n   = top_pop;
									if (top_pop != '0) begin
										top_dec  = top_pop - STK_CW'(1);
										s_re     = 1'b1;
										s_ra     = top_dec[STK_AW-1:0];
										tos_ld_n = 1'b1;
									end
								end
							end
						end
					end else if (!wp_q) begin
						// bits done: apply the trailer and close the item
						if (trl_q) begin
							if (phase_q == PH_TREE) begin
								phase_n = PH_BAD;
							end else if (phase_q == PH_DATA) begin
								phase_n = PH_END;
							end
						end
						state_n = CT_DONE;
					end

					// hold back one symbol so the last one can be flagged
					if (emit_v) begin
						if (hs_valid_q) begin
							dec_valid_n         = 1'b1;
							dec_n.out_symbol    = hs_sym_q;
							dec_n.symbol_valid  = 1'b1;
							dec_n.last_of_run   = 1'b0;
							dec_n.end_of_stream = eos_q;
							dec_n.malformed     = (phase_q == PH_BAD);
						end
						hs_valid_n = 1'b1;
						hs_sym_n   = emit_sym;
					end
				end
			end

			CT_DONE: begin
				// last result of the item, or a status result if nothing decoded
				if (out_free) begin
					dec_valid_n         = 1'b1;
					dec_n.out_symbol    = hs_valid_q ? hs_sym_q : 8'd0;
					dec_n.symbol_valid  = hs_valid_q;
					dec_n.last_of_run   = 1'b1;
					dec_n.end_of_stream = eos_q;
					dec_n.malformed     = (phase_q == PH_BAD);
					hs_valid_n          = 1'b0;
					state_n             = CT_IDLE;
				end
			end

			default: begin
				state_n = CT_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CT_IDLE;
			phase_q     <= PH_TREE;
			node_cnt_q  <= '0;
			stk_top_q   <= '0;
			tos_ld_q    <= 1'b0;
			leaf_left_q <= 4'd0;
			held_ok_q   <= 1'b0;
			bits_q      <= 4'd0;
			wp_q        <= 1'b0;
			trl_q       <= 1'b0;
			eos_q       <= 1'b0;
			hs_valid_q  <= 1'b0;
			dec_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			phase_q     <= phase_n;
			node_cnt_q  <= node_cnt_n;
			stk_top_q   <= stk_top_n;
			tos_ld_q    <= tos_ld_n;
			leaf_left_q <= leaf_left_n;
			held_ok_q   <= held_ok_n;
			bits_q      <= bits_n;
			wp_q        <= wp_n;
			trl_q       <= trl_n;
			eos_q       <= eos_n;
			hs_valid_q  <= hs_valid_n;
			dec_valid_q <= dec_valid_n;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		tos_q     <= tos_n;
		cur_idx_q <= cur_idx_n;
		leaf_sh_q <= leaf_sh_n;
		cur_l_q   <= cur_l_n;
		cur_r_q   <= cur_r_n;
		root_l_q  <= root_l_n;
		root_r_q  <= root_r_n;
		held_q    <= held_n;
		sh_q      <= sh_n;
		hs_sym_q  <= hs_sym_n;
		dec_q     <= dec_n;
	end

endmodule

FILE: hw/rtl/hsd_checker.sv
// ----------------------------------------------------------------------------
// hsd_checker: port-level checks for the huffman stream decoder
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsd_checker import hsd_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  comp_valid,
	input logic  comp_stall,
	input comp_t comp,
	input logic  dec_valid,
	input logic  dec_stall,
	input dec_t  dec
);

	logic bad_seen_q;

	// remember a delivered malformed status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_seen_q <= 1'b0;
		end else if (dec_valid && !dec_stall && dec.malformed) begin
			bad_seen_q <= 1'b1;
		end
	end

	// a stalled input item holds
	a_comp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		comp_valid && comp_stall |=> comp_valid && $stable(comp))
		else $error("input item changed while stalled");

	// a stalled item holds
	a_dec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_stall |=> dec_valid && $stable(dec))
		else $error("result item changed while stalled");

	// an item without a symbol carries status only and ends its run
	a_status_item: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec.symbol_valid |-> dec.out_symbol == 8'd0 && dec.last_of_run)
		else $error("status item with symbol or not last");

	// a malformed stream decodes nothing
	a_bad_no_sym: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec.malformed |-> !dec.symbol_valid)
		else $error("symbol on a malformed stream");

	// malformed is sticky
	a_bad_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		bad_seen_q && dec_valid |-> dec.malformed)
		else $error("malformed status cleared");

endmodule

bind huffman_stream_decoder hsd_checker u_hsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.comp_valid (comp_valid),
	.comp_stall (comp_stall),
	.comp       (comp),
	.dec_valid  (dec_valid),
	.dec_stall  (dec_stall),
	.dec        (dec)
);
